/* sv/mcst_pkg.sv */
// Shared types and constants for the multibyte character state tracker.
package mcst_pkg;

  // Character set selector codes
  typedef enum logic [3:0] {
    CS_SINGLE  = 4'd0,
    CS_UTF8    = 4'd1,
    CS_SJIS04  = 4'd2,
    CS_SJIS    = 4'd3,
    CS_BIG5    = 4'd4,
    CS_GBK     = 4'd5,
    CS_UHC     = 4'd6,
    CS_EUCJP   = 4'd7,
    CS_EUCCKJ  = 4'd8,
    CS_EUCTW   = 4'd9,
    CS_GB18030 = 4'd10
  } charset_t;

  // Configuration port geometry
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  // Register index, taken from the word address bits
  localparam logic REG_CHARSET_SEL = 1'b0;

  localparam int unsigned SEL_W    = 4;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned BYTE_W   = 8;

endpackage

/* sv/mcst_cfg.sv */
// Register file for the character set selector (APB-style write and read).
module mcst_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcst_pkg::CFG_AW-1:0]   paddr,
  input  logic [mcst_pkg::CFG_DW-1:0]   pwdata,
  output logic [mcst_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output logic [mcst_pkg::SEL_W-1:0]    charset_sel
);

  logic [mcst_pkg::SEL_W-1:0] sel_r;
  logic                       reg_hit;
  logic                       wr_en;

  assign reg_hit = (paddr[2] == mcst_pkg::REG_CHARSET_SEL);
  assign wr_en   = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;

  // Selector register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= mcst_pkg::SEL_W'(mcst_pkg::CS_SINGLE);
    end else if (wr_en) begin
      sel_r <= pwdata[mcst_pkg::SEL_W-1:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = {{(mcst_pkg::CFG_DW-mcst_pkg::SEL_W){1'b0}}, sel_r};
    end
  end

  assign charset_sel = sel_r;

endmodule

/* sv/mcst_core.sv */
// Input register, status update network, status and result registers.
module mcst_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [mcst_pkg::SEL_W-1:0]      charset_sel,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mcst_pkg::BYTE_W-1:0]     in_text_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mcst_pkg::STATUS_W-1:0]   out_char_status,
  output logic [2:0]                      out_max_char_len
);

  localparam logic [7:0] B_30 = 8'h30;
  localparam logic [7:0] B_39 = 8'h39;
  localparam logic [7:0] B_7F = 8'h7f;
  localparam logic [7:0] B_80 = 8'h80;
  localparam logic [7:0] B_81 = 8'h81;
  localparam logic [7:0] B_8E = 8'h8e;
  localparam logic [7:0] B_8F = 8'h8f;
  localparam logic [7:0] B_9F = 8'h9f;
  localparam logic [7:0] B_A0 = 8'hA0;
  localparam logic [7:0] B_C0 = 8'hc0;
  localparam logic [7:0] B_E0 = 8'he0;
  localparam logic [7:0] B_F0 = 8'hf0;
  localparam logic [7:0] B_F8 = 8'hf8;
  localparam logic [7:0] B_FC = 8'hfc;

  typedef logic [mcst_pkg::STATUS_W-1:0] status_t;

  // Common two-byte lead rule
  function automatic status_t two_byte(input status_t st, input logic lead);
    status_t r;
    r = 3'd0;
    if (st < 3'd2 && lead) r = 3'd2;
    else if (st == 3'd2)   r = 3'd1;
    return r;
  endfunction

  // Status after one byte
  function automatic status_t next_status(input status_t st_in, input logic [7:0] c,
                                          input logic [mcst_pkg::SEL_W-1:0] sel);
    status_t st;
    status_t r;
    logic    digit;
    st    = (c == 8'd0) ? 3'd0 : st_in;
    digit = (c >= B_30) && (c <= B_39);
    r     = 3'd0;
    unique case (sel)
      mcst_pkg::CS_UTF8: begin
        r = st;
        if (st < 3'd2 && c >= B_80) begin
          if (c >= B_FC)      r = 3'd6;
          else if (c >= B_F8) r = 3'd5;
          else if (c >= B_F0) r = 3'd4;
          else if (c >= B_E0) r = 3'd3;
          else if (c >= B_C0) r = 3'd2;
        end else if (st >= 3'd2 && c > B_7F) begin
          r = st - 3'd1;
        end else begin
          r = 3'd0;
        end
      end
      mcst_pkg::CS_SJIS04:
        r = two_byte(st, (c >= B_81 && c <= B_9F) || (c >= B_E0 && c <= B_FC));
      mcst_pkg::CS_SJIS:
        r = two_byte(st, c > B_80 && !(c > B_9F && c < B_E0));
      mcst_pkg::CS_BIG5, mcst_pkg::CS_EUCCKJ:
        r = two_byte(st, c > B_A0);
      mcst_pkg::CS_GBK, mcst_pkg::CS_UHC:
        r = two_byte(st, c > B_7F);
      mcst_pkg::CS_EUCJP: begin
        if (st < 3'd3 && c == B_8F)                      r = 3'd3;
        else if (st != 3'd2 && (c == B_8E || c > B_A0))  r = 3'd2;
        else if (st == 3'd2)                             r = 3'd1;
        else                                             r = 3'd0;
      end
      mcst_pkg::CS_EUCTW: begin
        if (st < 3'd4 && c == B_8E)                          r = 3'd4;
        else if (st == 3'd4 && c > B_A0)                     r = 3'd3;
        else if ((st == 3'd3 || st < 3'd2) && c > B_A0)      r = 3'd2;
        else if (st == 3'd2)                                 r = 3'd1;
        else                                                 r = 3'd0;
      end
      mcst_pkg::CS_GB18030: begin
        if (st < 3'd2 && c > B_80) r = 3'd2;
        else if (st == 3'd2)       r = digit ? 3'd3 : 3'd1;
        else if (st == 3'd3)       r = digit ? 3'd1 : 3'd3;
        else                       r = 3'd0;
      end
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // Largest character length of the selected set
  function automatic logic [2:0] max_len(input logic [mcst_pkg::SEL_W-1:0] sel);
    logic [2:0] r;
    unique case (sel)
      mcst_pkg::CS_UTF8, mcst_pkg::CS_EUCTW:     r = 3'd4;
      mcst_pkg::CS_EUCJP, mcst_pkg::CS_GB18030:  r = 3'd3;
      mcst_pkg::CS_SJIS04, mcst_pkg::CS_SJIS, mcst_pkg::CS_BIG5,
      mcst_pkg::CS_GBK, mcst_pkg::CS_UHC, mcst_pkg::CS_EUCCKJ: r = 3'd2;
      default:                                   r = 3'd1;
    endcase
    return r;
  endfunction

  logic                          in_valid_r;
  logic [mcst_pkg::BYTE_W-1:0]   in_byte_r;
  logic                          out_valid_r;
  status_t                       status_r;
  status_t                       status_nxt;
  logic [2:0]                    max_len_r;
  logic                          out_free;
  logic                          advance;

  // Handshake: output register frees when empty or taken
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  assign status_nxt = next_status(status_r, in_byte_r, charset_sel);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_text_byte;
    end
  end

  // Status and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      status_r    <= 3'd0;
    end else begin
      if (out_free) out_valid_r <= in_valid_r;
      if (advance)  status_r    <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      max_len_r <= max_len(charset_sel);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_char_status  = status_r;
  assign out_max_char_len = max_len_r;

endmodule

/* sv/multibyte_char_state_tracker.sv */
// Timing: an accepted byte passes through the input register, then the result
// register; an output stall holds the result in the result register.
// Throughput: one byte per cycle while the output is not stalled; the status update
// is a single compare network between the input register and the status register.
// Reset (rst_n low, synchronous): status 0, selector single-byte, both stages empty.
// The selector register sits on the APB-style port at byte address 0.
module multibyte_char_state_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcst_pkg::CFG_AW-1:0]   paddr,
  input  logic [mcst_pkg::CFG_DW-1:0]   pwdata,
  output logic [mcst_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_text_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_char_status,
  output logic [2:0]                    out_max_char_len
);

  logic [mcst_pkg::SEL_W-1:0] charset_sel;

  mcst_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .charset_sel (charset_sel)
  );

  mcst_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .charset_sel      (charset_sel),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char_status  (out_char_status),
    .out_max_char_len (out_max_char_len)
  );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the multibyte character state tracker.
module tb;

  localparam int LONG_HOLD   = 300;
  localparam int PHASE_BYTES = 62;
  localparam int NUM_PHASES  = 20;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] max_len;
  } char_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [mcst_pkg::CFG_AW-1:0] paddr = '0;
  logic [mcst_pkg::CFG_DW-1:0] pwdata = '0;
  logic [mcst_pkg::CFG_DW-1:0] prdata;
  logic                        pready;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [7:0]                  in_text_byte = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [2:0]                  out_char_status;
  logic [2:0]                  out_max_char_len;

  // text bytes waiting to be sent, and results the tracker owes us
  logic [7:0]   pending_q[$];
  char_result_t status_expect_q[$];

  // predictor state
  logic [2:0] pred_status = '0;
  logic [3:0] pred_sel = mcst_pkg::CS_SINGLE;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int errors = 0;
  int results_checked = 0;
  int bytes_accepted = 0;
  int bytes_queued = 0;
  int settings_used = 0;

  multibyte_char_state_tracker DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_status (out_char_status),
    .out_max_char_len(out_max_char_len)
  );

  always #5 clk = ~clk;

  // Two-byte sets: a lead opens a character, the next byte closes it
  function automatic logic [2:0] two_byte_status(logic [2:0] st, logic lead);
    if (st < 3'd2 && lead) return 3'd2;
    if (st == 3'd2) return 3'd1;
    return 3'd0;
  endfunction

  // Status after one text byte under the given selector
  function automatic logic [2:0] next_char_status(logic [2:0] st, logic [7:0] c,
                                                  logic [3:0] sel);
    logic digit;
    digit = (c >= 8'h30 && c <= 8'h39);
    if (c == 8'h00) st = 3'd0;
    case (sel)
      mcst_pkg::CS_UTF8: begin
        if (st < 3'd2 && c >= 8'h80) begin
          // stray continuation bytes fall through and keep the status
          if (c >= 8'hfc) st = 3'd6;
          else if (c >= 8'hf8) st = 3'd5;
          else if (c >= 8'hf0) st = 3'd4;
          else if (c >= 8'he0) st = 3'd3;
          else if (c >= 8'hc0) st = 3'd2;
        end else if (st >= 3'd2 && c > 8'h7f) begin
          st = st - 3'd1;
        end else begin
          st = 3'd0;
        end
        return st;
      end
      mcst_pkg::CS_SJIS04:
        return two_byte_status(st, (c >= 8'h81 && c <= 8'h9f) || (c >= 8'he0 && c <= 8'hfc));
      mcst_pkg::CS_SJIS:
        return two_byte_status(st, c > 8'h80 && !(c > 8'h9f && c < 8'he0));
      mcst_pkg::CS_BIG5, mcst_pkg::CS_EUCCKJ:
        return two_byte_status(st, c > 8'ha0);
      mcst_pkg::CS_GBK, mcst_pkg::CS_UHC:
        return two_byte_status(st, c > 8'h7f);
      mcst_pkg::CS_EUCJP: begin
        if (st < 3'd3 && c == 8'h8f) return 3'd3;
        if (st != 3'd2 && (c == 8'h8e || c > 8'ha0)) return 3'd2;
        if (st == 3'd2) return 3'd1;
        return 3'd0;
      end
      mcst_pkg::CS_EUCTW: begin
        if (st < 3'd4 && c == 8'h8e) return 3'd4;
        if (st == 3'd4 && c > 8'ha0) return 3'd3;
        if ((st == 3'd3 || st < 3'd2) && c > 8'ha0) return 3'd2;
        if (st == 3'd2) return 3'd1;
        return 3'd0;
      end
      mcst_pkg::CS_GB18030: begin
        if (st < 3'd2 && c > 8'h80) return 3'd2;
        if (st == 3'd2) return digit ? 3'd3 : 3'd1;
        // missing second digit holds status 3
        if (st == 3'd3) return digit ? 3'd1 : 3'd3;
        return 3'd0;
      end
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [2:0] char_len_limit(logic [3:0] sel);
    case (sel)
      mcst_pkg::CS_UTF8, mcst_pkg::CS_EUCTW:    return 3'd4;
      mcst_pkg::CS_EUCJP, mcst_pkg::CS_GB18030: return 3'd3;
      mcst_pkg::CS_SJIS04, mcst_pkg::CS_SJIS, mcst_pkg::CS_BIG5,
      mcst_pkg::CS_GBK, mcst_pkg::CS_UHC, mcst_pkg::CS_EUCCKJ: return 3'd2;
      default:                                  return 3'd1;
    endcase
  endfunction

  function automatic logic [7:0] rand_byte(int lo, int hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  // Input driver: predicts on accept, then offers the next queued byte
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pred_status = next_char_status(pred_status, in_text_byte, pred_sel);
        status_expect_q.push_back('{pred_status, char_len_limit(pred_sel)});
        bytes_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid     <= 1'b1;
          in_text_byte <= pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output stall: random, or a long hold when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_served + 1;
      hold_left   <= LONG_HOLD;
      out_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    char_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (status_expect_q.size() == 0) begin
        $error("result with nothing pending: char_status %0d max_char_len %0d",
               out_char_status, out_max_char_len);
        errors++;
      end else begin
        want = status_expect_q.pop_front();
        results_checked++;
        if (out_char_status !== want.status) begin
          $error("char_status mismatch: expected %0d, got %0d", want.status, out_char_status);
          errors++;
        end
        if (out_max_char_len !== want.max_len) begin
          $error("max_char_len mismatch: expected %0d, got %0d",
                 want.max_len, out_max_char_len);
          errors++;
        end
      end
    end
  end

  // Selector write over the config port, only while the tracker is idle
  task automatic set_charset(input logic [3:0] sel);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {mcst_pkg::REG_CHARSET_SEL, 2'b00};
    pwdata  <= mcst_pkg::CFG_DW'(sel);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pred_sel = sel;
    settings_used++;
  endtask

  // Wait until every byte is sent and every result is back
  task automatic drain();
    while (pending_q.size() != 0 || in_valid || status_expect_q.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Queue one character of the given set; some noise and truncated sequences
  task automatic queue_char(input logic [3:0] sel);
    logic [7:0] seq[$];
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 15) begin
      seq.push_back(8'($urandom));
    end else if (kind < 35) begin
      seq.push_back(rand_byte(0, 8'h7f));
    end else begin
      case (sel)
        mcst_pkg::CS_UTF8: begin
          n = ($urandom_range(9) == 0) ? $urandom_range(6, 5) : $urandom_range(4, 2);
          case (n)
            2: seq.push_back(8'hc0 | rand_byte(0, 31));
            3: seq.push_back(8'he0 | rand_byte(0, 15));
            4: seq.push_back(8'hf0 | rand_byte(0, 7));
            5: seq.push_back(8'hf8 | rand_byte(0, 3));
            default: seq.push_back(8'hfc | rand_byte(0, 1));
          endcase
          repeat (n - 1) seq.push_back(8'h80 | rand_byte(0, 63));
        end
        mcst_pkg::CS_SJIS04, mcst_pkg::CS_SJIS: begin
          seq.push_back($urandom_range(1) ? rand_byte(8'h81, 8'h9f) : rand_byte(8'he0, 8'hfc));
          seq.push_back(rand_byte(8'h40, 8'hfc));
        end
        mcst_pkg::CS_BIG5, mcst_pkg::CS_EUCCKJ: begin
          seq.push_back(rand_byte(8'ha1, 8'hfe));
          seq.push_back(rand_byte(8'h40, 8'hfe));
        end
        mcst_pkg::CS_GBK, mcst_pkg::CS_UHC: begin
          seq.push_back(rand_byte(8'h81, 8'hfe));
          seq.push_back(rand_byte(8'h41, 8'hfe));
        end
        mcst_pkg::CS_EUCJP: begin
          case ($urandom_range(2))
            0: begin
              seq.push_back(8'h8e);
              seq.push_back(rand_byte(8'ha1, 8'hdf));
            end
            1: begin
              seq.push_back(8'h8f);
              seq.push_back(rand_byte(8'ha1, 8'hfe));
              seq.push_back(rand_byte(8'ha1, 8'hfe));
            end
            default: begin
              seq.push_back(rand_byte(8'ha1, 8'hfe));
              seq.push_back(rand_byte(8'ha1, 8'hfe));
            end
          endcase
        end
        mcst_pkg::CS_EUCTW: begin
          if ($urandom_range(1)) begin
            seq.push_back(8'h8e);
            seq.push_back(rand_byte(8'ha1, 8'hb0));
          end
          seq.push_back(rand_byte(8'ha1, 8'hfe));
          seq.push_back(rand_byte(8'ha1, 8'hfe));
        end
        mcst_pkg::CS_GB18030: begin
          seq.push_back(rand_byte(8'h81, 8'hfe));
          if ($urandom_range(1)) begin
            seq.push_back(rand_byte(8'h40, 8'hfe));
          end else begin
            seq.push_back(rand_byte(8'h30, 8'h39));
            seq.push_back(rand_byte(8'h81, 8'hfe));
            seq.push_back(rand_byte(8'h30, 8'h39));
          end
        end
        default: seq.push_back(8'($urandom));
      endcase
      // occasionally cut the character short
      if (seq.size() > 1 && $urandom_range(9) == 0) void'(seq.pop_back());
    end
    foreach (seq[i]) pending_q.push_back(seq[i]);
    bytes_queued += seq.size();
  endtask

  // Stimulus and end of run
  initial begin
    logic [3:0] phase_sel[NUM_PHASES];
    int target;
    phase_sel = '{mcst_pkg::CS_UTF8, mcst_pkg::CS_GB18030, mcst_pkg::CS_SINGLE,
                  mcst_pkg::CS_SJIS04, mcst_pkg::CS_SJIS, mcst_pkg::CS_BIG5,
                  mcst_pkg::CS_GBK, mcst_pkg::CS_UHC, mcst_pkg::CS_EUCJP,
                  mcst_pkg::CS_EUCCKJ, mcst_pkg::CS_EUCTW, 4'd15, 4'd11,
                  mcst_pkg::CS_UTF8, mcst_pkg::CS_GB18030, mcst_pkg::CS_EUCJP,
                  mcst_pkg::CS_EUCTW, 4'd12, 4'd13, 4'd14};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // UTF-8: stray continuations, lead bytes, zero byte mid-character
    set_charset(mcst_pkg::CS_UTF8);
    pending_q = {pending_q, 8'h80, 8'he3, 8'hbf, 8'h80, 8'hc3, 8'ha9, 8'h80, 8'hfc,
                 8'h00, 8'hff, 8'h7f};
    drain();
    // GB18030: non-digit where the second digit belongs; end inside a character
    set_charset(mcst_pkg::CS_GB18030);
    pending_q = {pending_q, 8'h81, 8'h35, 8'h41, 8'h39, 8'h81};
    drain();
    // switch set with status still open
    set_charset(mcst_pkg::CS_EUCTW);
    pending_q = {pending_q, 8'hb0, 8'h8e, 8'ha1, 8'ha1, 8'ha1};
    drain();
    // unused selector code
    set_charset(4'd15);
    pending_q = {pending_q, 8'hff, 8'h00};
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_charset(phase_sel[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 58; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      // long output hold while bytes keep coming, to back up the pipe
      if (p == 0) hold_asked++;
      // two halves; the sender pauses for all results in between
      repeat (2) begin
        target = bytes_queued + PHASE_BYTES / 2;
        while (bytes_queued < target) queue_char(phase_sel[p]);
        drain();
      end
    end

    repeat (6) @(posedge clk);
    if (status_expect_q.size() != 0) begin
      $error("%0d results never arrived", status_expect_q.size());
      errors++;
    end
    $display("Run covered %0d text bytes and %0d checked results over %0d selector writes,",
             bytes_accepted, results_checked, settings_used);
    $display("including unused codes, sets switched mid-character and a long output hold.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule
